@@ rtl/vrct_pkg.sv @@
// vrct_pkg: shared constants and codes for the value range count table.
// No dependencies; every other file of the block refers to it by scoped names.
package vrct_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_VALUE_BITS  = 30;
	localparam int SLOT_BITS       = 10;
	localparam int COUNT_BITS      = 11;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic {
		OP_SET   = 1'b0,
		OP_COUNT = 1'b1
	} op_t;

endpackage

@@ rtl/vrct_in_if.sv @@
// vrct_in_if: request channel of the value range count table.
// Depends on vrct_pkg for the slot width and the default value width.
interface vrct_in_if #(
	parameter int VALUE_BITS = vrct_pkg::DEF_VALUE_BITS
);
	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic [vrct_pkg::SLOT_BITS-1:0] slot;
	logic [VALUE_BITS-1:0]          new_value;
	logic [VALUE_BITS-1:0]          range_low;
	logic [VALUE_BITS-1:0]          range_high;

	modport source (
		output valid, opcode, slot, new_value, range_low, range_high,
		input  ready
	);
	modport sink (
		input  valid, opcode, slot, new_value, range_low, range_high,
		output ready
	);
endinterface

@@ rtl/vrct_out_if.sv @@
// vrct_out_if: result channel of the value range count table.
// Depends on vrct_pkg for the count width.
interface vrct_out_if;
	logic                            valid;
	logic                            ready;
	logic [vrct_pkg::COUNT_BITS-1:0] match_count;

	modport source (
		output valid, match_count,
		input  ready
	);
	modport sink (
		input  valid, match_count,
		output ready
	);
endinterface

@@ rtl/vrct_front.sv @@
// vrct_front: accepts requests, drops sets outside the table, flags empty ranges
// and packs each request into a queue entry. Depends on vrct_pkg, vrct_in_if.
module vrct_front #(
	parameter int TABLE_DEPTH = vrct_pkg::DEF_TABLE_DEPTH,
	parameter int VALUE_BITS  = vrct_pkg::DEF_VALUE_BITS,
	parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	parameter int ENTRY_W     = 2 + IDX_W + 2 * VALUE_BITS
) (
	vrct_in_if.sink             request,
	input  logic                clearing,
	input  logic                q_full,
	output logic                push,
	output logic [ENTRY_W-1:0]  push_data
);

	logic                  is_count;
	logic                  slot_ok;
	logic                  empty_range;
	logic [VALUE_BITS-1:0] operand_a;

	always_comb begin
		is_count    = (request.opcode == vrct_pkg::OP_COUNT);
		slot_ok     = (32'(request.slot) < TABLE_DEPTH);
		empty_range = (request.range_low > request.range_high);
		operand_a   = is_count ? request.range_low : request.new_value;
		request.ready = !clearing && !q_full;
		// a set aimed past the table is taken and silently dropped
		push = request.valid && request.ready && (is_count || slot_ok);
		push_data = {request.opcode, empty_range, IDX_W'(request.slot),
			operand_a, request.range_high};
	end

endmodule

@@ rtl/vrct_queue.sv @@
// vrct_queue: small flop-based FIFO between the front and the back end.
// Depends on vrct_pkg for the default depth.
module vrct_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = vrct_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_vld,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign pop_vld  = (cnt_q != '0);
	assign pop_data = slots_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && pop_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/vrct_back.sv @@
// vrct_back: entry memory, clearing pass, range scan and result register.
// Depends on vrct_pkg and vrct_out_if; fed by vrct_queue.
module vrct_back #(
	parameter int TABLE_DEPTH = vrct_pkg::DEF_TABLE_DEPTH,
	parameter int VALUE_BITS  = vrct_pkg::DEF_VALUE_BITS,
	parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	parameter int ENTRY_W     = 2 + IDX_W + 2 * VALUE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_vld,
	input  logic [ENTRY_W-1:0] pop_data,
	output logic               pop,
	output logic               clearing,
	vrct_out_if.source         result
);

	localparam int CB = vrct_pkg::COUNT_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	// memory word: {valid, value}
	logic [VALUE_BITS:0]   entry_mem [TABLE_DEPTH];
	logic [VALUE_BITS:0]   rd_data_s1;
	logic                  rd_vld_s1;
	logic                  vld_s2;
	logic                  hit_s2;

	logic [IDX_W-1:0]      scan_idx_q;
	logic [VALUE_BITS-1:0] lo_q;
	logic [VALUE_BITS-1:0] hi_q;
	logic [CB-1:0]         count_q;
	logic                  res_vld_q;
	logic [CB-1:0]         res_count_q;

	logic                  e_op;
	logic                  e_empty;
	logic [IDX_W-1:0]      e_idx;
	logic [VALUE_BITS-1:0] e_a;
	logic [VALUE_BITS-1:0] e_b;

	logic                  mem_we;
	logic [IDX_W-1:0]      wr_idx;
	logic [VALUE_BITS:0]   wr_word;
	logic                  res_load;

	always_comb begin
		e_b     = pop_data[VALUE_BITS-1:0];
		e_a     = pop_data[2*VALUE_BITS-1:VALUE_BITS];
		e_idx   = pop_data[2*VALUE_BITS +: IDX_W];
		e_empty = pop_data[2*VALUE_BITS + IDX_W];
		e_op    = pop_data[2*VALUE_BITS + IDX_W + 1];

		clearing = (state_q == ST_CLEAR);
		pop      = (state_q == ST_IDLE) && pop_vld;

		mem_we  = clearing || (pop && (e_op == vrct_pkg::OP_SET));
		wr_idx  = clearing ? scan_idx_q : e_idx;
		wr_word = clearing ? '0 : {1'b1, e_a};

		res_load = (state_q == ST_DONE) && (!res_vld_q || result.ready);

		result.valid       = res_vld_q;
		result.match_count = res_count_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[wr_idx] <= wr_word;
		end
		rd_data_s1 <= entry_mem[scan_idx_q];
	end

	always_ff @(posedge clk) begin
		if (pop && (e_op == vrct_pkg::OP_COUNT)) begin
			lo_q <= e_a;
			hi_q <= e_b;
		end
		hit_s2 <= rd_vld_s1 && rd_data_s1[VALUE_BITS]
			&& (rd_data_s1[VALUE_BITS-1:0] >= lo_q)
			&& (rd_data_s1[VALUE_BITS-1:0] <= hi_q);
		if (res_load) begin
			res_count_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			vld_s2     <= 1'b0;
			count_q    <= '0;
			res_vld_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			vld_s2    <= rd_vld_s1;

			if (vld_s2 && hit_s2 && (count_q != vrct_pkg::COUNT_MAX)) begin
				count_q <= count_q + 1'b1;
			end

			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					if (scan_idx_q == LAST_IDX) begin
						scan_idx_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (pop && (e_op == vrct_pkg::OP_COUNT)) begin
						count_q    <= '0;
						scan_idx_q <= '0;
						state_q    <= e_empty ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!rd_vld_s1 && !vld_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DRAIN) |-> !mem_we)
		else $error("table written during a range scan");

	a_queue_empty_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !pop_vld)
		else $error("request queued before the clearing pass ended");

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> ($past(state_q) == ST_SCAN))
		else $error("scan data valid without a scan read");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rd_vld_s1 && !vld_s2))
		else $error("scan pipeline busy while idle");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !res_vld_q) |=> res_vld_q)
		else $error("finished count not moved to the result register");

endmodule

@@ rtl/value_range_count_table.sv @@
// value_range_count_table: top level; front classifier, queue and scan back end.
// Depends on vrct_pkg, vrct_in_if, vrct_out_if, vrct_front, vrct_queue, vrct_back.
//
//   channel   dir   handshake       payload
//   request   in    valid / ready   opcode, slot, new_value, range_low, range_high
//   result    out   valid / ready   match_count
//
// After reset a clearing pass walks every entry of the entry memory with
// request.ready low. A set is written into the entry memory as it leaves the queue;
// a count scans every entry through the single read port of the entry memory
// (one entry per cycle), then loads the result register. An empty range skips the
// scan. The two-entry queue lets requests be taken while a scan runs; the result
// register holds one count while the back end goes on with queued sets.
module value_range_count_table #(
	parameter int TABLE_DEPTH = vrct_pkg::DEF_TABLE_DEPTH,
	parameter int VALUE_BITS  = vrct_pkg::DEF_VALUE_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	vrct_in_if.sink    request,
	vrct_out_if.source result
);

	localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ENTRY_W = 2 + IDX_W + 2 * VALUE_BITS;

	logic               clearing;
	logic               q_full;
	logic               push;
	logic [ENTRY_W-1:0] push_data;
	logic               pop;
	logic               pop_vld;
	logic [ENTRY_W-1:0] pop_data;

	vrct_front #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_BITS  (VALUE_BITS),
		.IDX_W       (IDX_W),
		.ENTRY_W     (ENTRY_W)
	) u_front (
		.request   (request),
		.clearing  (clearing),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	vrct_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (vrct_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_vld   (pop_vld),
		.pop_data  (pop_data)
	);

	vrct_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_BITS  (VALUE_BITS),
		.IDX_W       (IDX_W),
		.ENTRY_W     (ENTRY_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_vld  (pop_vld),
		.pop_data (pop_data),
		.pop      (pop),
		.clearing (clearing),
		.result   (result)
	);

endmodule
